// ----- rtl/dfr_pkg.sv -----
`default_nettype none
package dfr_pkg;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int INDEX_W = 16;

  // register index, taken from paddr[2]
  localparam logic REG_OUTSIDE = 1'b0;
  localparam logic REG_INSIDE  = 1'b1;

  localparam logic [INDEX_W-1:0] OUTSIDE_RESET = 16'd4096;
  localparam logic [INDEX_W-1:0] INSIDE_RESET  = 16'd6144;

  // result kind
  localparam logic [1:0] CASE_FORMULA = 2'd0;
  localparam logic [1:0] CASE_EQUAL   = 2'd1;
  localparam logic [1:0] CASE_TIR     = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/dfr_if.sv -----
`default_nettype none
interface dfr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_incident;
  modport source(output valid, output cos_incident, input ready);
  modport sink(input valid, input cos_incident, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reflectance;
  logic [1:0]  case_code;
  modport source(output valid, output reflectance, output case_code, input ready);
  modport sink(input valid, input reflectance, input case_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/dfr_front.sv -----
`default_nettype none
module dfr_front #(
  parameter int F = 15,
  localparam int EW = 2 * F + 35
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [15:0] cos_incident,
  input  wire logic [15:0]       outside_index,
  input  wire logic [15:0]       inside_index,
  input  wire logic              full,
  output logic                   push,
  output logic [EW-1:0]          push_data
);

  localparam int CMW = (F + 1 > 17) ? F + 1 : 17;
  localparam int SQW = 2 * F + 2;
  localparam logic [CMW-1:0] ONE_C  = CMW'(1) << F;
  localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * F);

  logic        valid;
  logic        eq;
  logic [15:0] raw;
  logic [15:0] eta_i;
  logic [15:0] eta_t;

  logic [16:0]    mag;
  logic [CMW-1:0] mag_w;
  logic [F:0]     c;
  logic [SQW-1:0] sq;
  logic [SQW-1:0] diff;
  logic [F:0]     s;

  assign in_ready = !valid || !full;
  assign push     = valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // swap the indices when the ray starts inside
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      raw   <= cos_incident;
      eq    <= (outside_index == inside_index);
      eta_i <= cos_incident[15] ? inside_index : outside_index;
      eta_t <= cos_incident[15] ? outside_index : inside_index;
    end
  end

  always_comb begin
    mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    mag_w = CMW'(mag);
    c     = (mag_w > ONE_C) ? ONE_C[F:0] : mag_w[F:0];
    sq    = SQW'(c) * SQW'(c);
    diff  = ONE_SQ - sq;
    s     = diff[2*F:F];
  end

  assign push_data = {eq, eta_i, eta_t, c, s};

endmodule
`default_nettype wire

// ----- rtl/dfr_fifo.sv -----
`default_nettype none
module dfr_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_drain: assert property (@(posedge clk) disable iff (rst)
      do_pop && !do_push && cnt == CW'(1) |=> empty)
    else $error("queue not empty after last pop");

endmodule
`default_nettype wire

// ----- rtl/dfr_div.sv -----
`default_nettype none
module dfr_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [QW-1:0]      quot,
  output logic [TW-1:0]      out_tag
);

  localparam int LW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_r [QW];
  logic [LW-1:0] rem_r [QW];
  logic [DW-1:0] d_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic [TW-1:0] tag_r [QW];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic          vin;
    logic [LW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [TW-1:0] tin;
    logic [LW-1:0] sd;
    logic          ge;

    if (k == 0) begin : g_head
      assign vin = in_vld;
      assign rin = LW'(dividend);
      assign din = divisor;
      assign qin = '0;
      assign tin = in_tag;
    end else begin : g_body
      assign vin = vld_r[k-1];
      assign rin = rem_r[k-1];
      assign din = d_r[k-1];
      assign qin = q_r[k-1];
      assign tin = tag_r[k-1];
    end

    assign sd = LW'(din) << B;
    assign ge = (rin >= sd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rin - sd : rin;
        d_r[k]   <= din;
        q_r[k]   <= ge ? (qin | (QW'(1) << B)) : qin;
        tag_r[k] <= tin;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign quot    = q_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule
`default_nettype wire

// ----- rtl/dfr_sqrt.sv -----
`default_nettype none
module dfr_sqrt #(
  parameter int RW = 16,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [2*RW-1:0] radicand,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_vld,
  output logic [RW-1:0]        root,
  output logic [TW-1:0]        out_tag
);

  localparam int VW  = 2 * RW;
  localparam int RMW = RW + 3;

  logic           vld_r  [RW];
  logic [VW-1:0]  v_r    [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [TW-1:0]  tag_r  [RW];

  // one root bit per stage from two radicand bits
  for (genvar k = 0; k < RW; k++) begin : g_st
    logic           vin;
    logic [VW-1:0]  vv;
    logic [RMW-1:0] rin;
    logic [RW-1:0]  oin;
    logic [TW-1:0]  tin;
    logic [RMW-1:0] r4;
    logic [RMW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_head
      assign vin = in_vld;
      assign vv  = radicand;
      assign rin = '0;
      assign oin = '0;
      assign tin = in_tag;
    end else begin : g_body
      assign vin = vld_r[k-1];
      assign vv  = v_r[k-1];
      assign rin = rem_r[k-1];
      assign oin = root_r[k-1];
      assign tin = tag_r[k-1];
    end

    assign r4    = {rin[RMW-3:0], vv[VW-1-2*k -: 2]};
    assign trial = RMW'({oin, 2'b01});
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= vv;
        rem_r[k]  <= ge ? r4 - trial : r4;
        root_r[k] <= {oin[RW-2:0], ge};
        tag_r[k]  <= tin;
      end
    end
  end

  assign out_vld = vld_r[RW-1];
  assign root    = root_r[RW-1];
  assign out_tag = tag_r[RW-1];

endmodule
`default_nettype wire

// ----- rtl/dfr_back.sv -----
`default_nettype none
module dfr_back #(
  parameter int F = 15,
  localparam int EW = 2 * F + 35
) (
  input  wire logic          clk,
  input  wire logic          rst,
  output logic               pop,
  input  wire logic          empty,
  input  wire logic [EW-1:0] pop_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        reflectance,
  output logic [1:0]         case_code
);

  localparam int QW  = F + 1;
  localparam int PW2 = F + 33;
  localparam int PW  = F + 17;
  localparam int DNW = F + 18;
  localparam int DNX = (DNW > 33) ? DNW : 33;
  localparam int SHW = $clog2(DNX);
  localparam int TW1 = F + 35;
  localparam int VW  = 2 * F + 2;
  localparam int SQW = 2 * F + 2;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
  localparam logic [15:0]   ONE16 = 16'(64'(1) << F);

  logic en;

  // b0: queue head
  logic          b0_v, b0_eq;
  logic [15:0]   b0_ei, b0_et;
  logic [F:0]    b0_c, b0_s;
  // b1: squared indices
  logic          b1_v, b1_eq;
  logic [15:0]   b1_ei, b1_et;
  logic [F:0]    b1_c, b1_s;
  logic [31:0]   b1_ei2, b1_et2;
  // b2: scaled sine
  logic          b2_v, b2_eq;
  logic [15:0]   b2_ei, b2_et;
  logic [F:0]    b2_c;
  logic [31:0]   b2_et2;
  logic [PW2-1:0] b2_p;
  logic          b2_tir;
  // sine divider and root
  logic           d1_v;
  logic [QW-1:0]  d1_q;
  logic [TW1-1:0] d1_tag;
  logic [QW-1:0]  sin2;
  logic [VW-1:0]  rad;
  logic           r_v;
  logic [QW-1:0]  r_cos;
  logic [TW1-1:0] r_tag;
  logic           r_eq, r_tir;
  logic [15:0]    r_ei, r_et;
  logic [F:0]     r_c;
  // b3: amplitude terms
  logic          b3_v, b3_eq, b3_tir;
  logic [PW-1:0] b3_as, b3_bs, b3_ap, b3_bp;
  // b4: normalized ratios
  logic          b4_v, b4_eq, b4_tir;
  logic [66:0]   b4_s, b4_p;
  // ratio dividers
  logic          da_v, db_v;
  logic [QW-1:0] da_q, db_q;
  logic [2:0]    da_tag;
  logic [0:0]    db_tag;
  // b6: squared ratios
  logic           b6_v, b6_eq, b6_tir;
  logic [SQW-1:0] b6_rs2, b6_rp2;
  logic [QW-1:0]  rs, rp;
  // output
  logic [SQW:0]   sum;
  logic [SQW:0]   r_full;
  logic [15:0]    r16;

  // {den == 0, num, den} with den brought below 2^33
  function automatic logic [66:0] prep(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [DNX-1:0] den;
    logic [DNX-1:0] num;
    logic [SHW-1:0] sh;
    den = DNX'(a) + DNX'(b);
    num = (a >= b) ? DNX'(a) - DNX'(b) : DNX'(b) - DNX'(a);
    sh  = '0;
    for (int i = 33; i < DNX; i++) begin
      if (den[i]) sh = SHW'(i - 32);
    end
    den = den >> sh;
    num = num >> sh;
    return {(den == '0), num[32:0], den[32:0]};
  endfunction

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b6_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b0_v <= !empty;
      b1_v <= b0_v;
      b2_v <= b1_v;
      b3_v <= r_v;
      b4_v <= b3_v;
      b6_v <= da_v && db_v;
      out_valid <= b6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {b0_eq, b0_ei, b0_et, b0_c, b0_s} <= pop_data;

      b1_eq  <= b0_eq;
      b1_ei  <= b0_ei;
      b1_et  <= b0_et;
      b1_c   <= b0_c;
      b1_s   <= b0_s;
      b1_ei2 <= b0_ei * b0_ei;
      b1_et2 <= b0_et * b0_et;

      b2_eq  <= b1_eq;
      b2_ei  <= b1_ei;
      b2_et  <= b1_et;
      b2_c   <= b1_c;
      b2_et2 <= b1_et2;
      b2_p   <= PW2'(b1_ei2) * PW2'(b1_s);
    end
  end

  // total internal reflection, also for a zero transmitted index
  assign b2_tir = (b2_et == '0) || (b2_p > (PW2'(b2_et2) << F));

  dfr_div #(.NW(PW2), .DW(32), .QW(QW), .TW(TW1)) u_sin_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(b2_v), .dividend(b2_p), .divisor(b2_et2),
    .in_tag({b2_eq, b2_tir, b2_ei, b2_et, b2_c}),
    .out_vld(d1_v), .quot(d1_q), .out_tag(d1_tag)
  );

  assign sin2 = (d1_q > ONE_Q) ? ONE_Q : d1_q;
  assign rad  = VW'(ONE_Q - sin2) << F;

  dfr_sqrt #(.RW(QW), .TW(TW1)) u_cos_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(d1_v), .radicand(rad), .in_tag(d1_tag),
    .out_vld(r_v), .root(r_cos), .out_tag(r_tag)
  );

  assign {r_eq, r_tir, r_ei, r_et, r_c} = r_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      b3_eq  <= r_eq;
      b3_tir <= r_tir;
      b3_as  <= PW'(r_ei) * PW'(r_c);
      b3_bs  <= PW'(r_et) * PW'(r_cos);
      b3_ap  <= PW'(r_et) * PW'(r_c);
      b3_bp  <= PW'(r_ei) * PW'(r_cos);

      b4_eq  <= b3_eq;
      b4_tir <= b3_tir;
      b4_s   <= prep(b3_as, b3_bs);
      b4_p   <= prep(b3_ap, b3_bp);
    end
  end

  dfr_div #(.NW(F + 33), .DW(33), .QW(QW), .TW(3)) u_rs_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(b4_v), .dividend({b4_s[65:33], {F{1'b0}}}), .divisor(b4_s[32:0]),
    .in_tag({b4_eq, b4_tir, b4_s[66]}),
    .out_vld(da_v), .quot(da_q), .out_tag(da_tag)
  );

  dfr_div #(.NW(F + 33), .DW(33), .QW(QW), .TW(1)) u_rp_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(b4_v), .dividend({b4_p[65:33], {F{1'b0}}}), .divisor(b4_p[32:0]),
    .in_tag(b4_p[66]),
    .out_vld(db_v), .quot(db_q), .out_tag(db_tag)
  );

  // a zero denominator counts as ratio one
  assign rs = da_tag[0] ? ONE_Q : da_q;
  assign rp = db_tag[0] ? ONE_Q : db_q;

  always_ff @(posedge clk) begin
    if (en) begin
      b6_eq  <= da_tag[2];
      b6_tir <= da_tag[1];
      b6_rs2 <= SQW'(rs) * SQW'(rs);
      b6_rp2 <= SQW'(rp) * SQW'(rp);
    end
  end

  always_comb begin
    sum    = (SQW + 1)'(b6_rs2) + (SQW + 1)'(b6_rp2);
    r_full = sum >> (F + 1);
    r16    = (r_full > (SQW + 1)'(ONE_Q)) ? ONE16 : r_full[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (b6_eq) begin
        reflectance <= '0;
        case_code   <= dfr_pkg::CASE_EQUAL;
      end else if (b6_tir) begin
        reflectance <= ONE16;
        case_code   <= dfr_pkg::CASE_TIR;
      end else begin
        reflectance <= r16;
        case_code   <= dfr_pkg::CASE_FORMULA;
      end
    end
  end

  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && case_code == dfr_pkg::CASE_EQUAL |-> reflectance == '0)
    else $error("equal indices gave nonzero reflectance");
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
      out_valid && case_code == dfr_pkg::CASE_TIR |-> reflectance == ONE16)
    else $error("total internal reflection not one");
  a_code_known: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (case_code == dfr_pkg::CASE_FORMULA ||
                     case_code == dfr_pkg::CASE_EQUAL ||
                     case_code == dfr_pkg::CASE_TIR))
    else $error("unknown case code");
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) da_v == db_v)
    else $error("ratio dividers out of step");

endmodule
`default_nettype wire

// ----- rtl/dielectric_fresnel_reflectance.sv -----
`default_nettype none
// Channel   Dir  Handshake        Payload
// rays      in   valid/ready      cos_incident  signed Q1.15
// refl      out  valid/ready      reflectance Q1.15, case_code
// apb       in   psel/penable     outside_index @0, inside_index @4
//
// Latency is set by the sine divider, the cosine square root and the two
// ratio dividers, each retiring one bit per stage. One item is accepted per
// cycle unless a full queue holds the front register.
// rst is synchronous; it empties the queue and pipeline and restores indices.
// A stalled refl freezes the back pipeline; the four-entry queue then fills
// before rays.ready drops.
module dielectric_fresnel_reflectance #(
  parameter int FRACTION_BITS = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  dfr_in_if.sink                          rays,
  dfr_out_if.source                       refl,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dfr_pkg::DATA_W-1:0] pwdata,
  output logic [dfr_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int EW = 2 * FRACTION_BITS + 35;

  logic [15:0]   outside_index;
  logic [15:0]   inside_index;
  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // register file: index picked by paddr[2]
  assign pready = 1'b1;
  assign prdata = {16'b0, (paddr[2] == dfr_pkg::REG_INSIDE) ? inside_index : outside_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      outside_index <= dfr_pkg::OUTSIDE_RESET;
      inside_index  <= dfr_pkg::INSIDE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        dfr_pkg::REG_OUTSIDE: outside_index <= pwdata[15:0];
        dfr_pkg::REG_INSIDE:  inside_index  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // front: take the cosine, fold the sign into the index order, form c and s
  dfr_front #(.F(FRACTION_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(rays.valid), .in_ready(rays.ready), .cos_incident(rays.cos_incident),
    .outside_index(outside_index), .inside_index(inside_index),
    .full(q_full), .push(q_push), .push_data(q_wdata)
  );

  // decouple front and back
  dfr_fifo #(.W(EW), .DEPTH(4)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  // back: sine, cosine root, amplitude ratios, average of squares
  dfr_back #(.F(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .pop(q_pop), .empty(q_empty), .pop_data(q_rdata),
    .out_valid(refl.valid), .out_ready(refl.ready),
    .reflectance(refl.reflectance), .case_code(refl.case_code)
  );

endmodule
`default_nettype wire

// ----- verif/dfr_checker.sv -----
module dfr_checker #(
  parameter int FRACTION_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic signed [15:0] in_cos,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_refl,
  input  logic [1:0]        out_case,
  input  logic              cfg_we,
  input  logic              cfg_sel,
  input  logic [15:0]       cfg_data,
  output int                failures,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] refl;
    logic [1:0]  kind;
  } shade_t;

  logic [15:0] eta_out;
  logic [15:0] eta_in;
  shade_t      shade_q[$];

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] ratio(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num;
    logic [63:0] den;
    num = (a >= b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd1 << FRACTION_BITS;
    while ((den >> 33) != 0) begin
      num = num >> 1;
      den = den >> 1;
    end
    return (num << FRACTION_BITS) / den;
  endfunction

  function automatic shade_t fresnel(input logic [15:0] raw);
    logic [63:0] one, ei, et, c, s, sin2, cost, rs, rp, r;
    shade_t res;
    one = 64'd1 << FRACTION_BITS;
    ei = eta_out;
    et = eta_in;
    if (ei == et) begin
      res.refl = 0;
      res.kind = dfr_pkg::CASE_EQUAL;
      return res;
    end
    if (raw[15]) begin
      ei = eta_in;
      et = eta_out;
      c = 64'h10000 - raw;
    end else begin
      c = raw;
    end
    if (c > one) c = one;
    s = (one * one - c * c) >> FRACTION_BITS;
    if (et == 0 || ei * ei * s > one * et * et) begin
      res.refl = one[15:0];
      res.kind = dfr_pkg::CASE_TIR;
      return res;
    end
    sin2 = (ei * ei * s) / (et * et);
    if (sin2 > one) sin2 = one;
    cost = root64((one - sin2) << FRACTION_BITS);
    rs = ratio(ei * c, et * cost);
    rp = ratio(et * c, ei * cost);
    r = (rs * rs + rp * rp) >> (FRACTION_BITS + 1);
    if (r > one) r = one;
    res.refl = r[15:0];
    res.kind = dfr_pkg::CASE_FORMULA;
    return res;
  endfunction

  assign pending = shade_q.size();

  always @(posedge clk) begin
    shade_t want;
    int errs;
    errs = 0;
    if (rst) begin
      eta_out <= dfr_pkg::OUTSIDE_RESET;
      eta_in <= dfr_pkg::INSIDE_RESET;
      failures <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == dfr_pkg::REG_OUTSIDE) eta_out <= cfg_data;
        else eta_in <= cfg_data;
      end
      if (in_valid && in_ready) shade_q = {shade_q, fresnel(in_cos)};
      if (out_valid && out_ready) begin
        if (shade_q.size() == 0) begin
          $error("unexpected item: reflectance %0d case %0d", out_refl, out_case);
          errs++;
        end else begin
          want = shade_q.pop_front();
          if (want.refl !== out_refl) begin
            $error("reflectance: expected %0d, actual %0d", want.refl, out_refl);
            errs++;
          end
          if (want.kind !== out_case) begin
            $error("case_code: expected %0d, actual %0d", want.kind, out_case);
            errs++;
          end
        end
      end
      failures <= failures + errs;
    end
  end
endmodule

// ----- verif/dielectric_fresnel_reflectance_tb.sv -----
module dielectric_fresnel_reflectance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 56;
  localparam int RANDOM_ITEMS = 1300;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [dfr_pkg::ADDR_W-1:0] paddr;
  logic [dfr_pkg::DATA_W-1:0] pwdata;
  logic [dfr_pkg::DATA_W-1:0] prdata;
  logic pready;
  int failures;
  int pending;
  longint cycles;
  bit stim_done;
  bit sink_hold;   // long receiver hold-off, asked by the stimulus
  bit steady;      // stretch with no idling on either side

  dfr_in_if rays();
  dfr_out_if refl();

  dielectric_fresnel_reflectance dut (
    .clk(clk), .rst(rst), .rays(rays.sink), .refl(refl.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dfr_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(rays.valid), .in_ready(rays.ready), .in_cos(rays.cos_incident),
    .out_valid(refl.valid), .out_ready(refl.ready),
    .out_refl(refl.reflectance), .out_case(refl.case_code),
    .cfg_we(psel && penable && pwrite && pready),
    .cfg_sel(paddr[2]), .cfg_data(pwdata[15:0]),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stalls, no stalls in the steady stretch, and a long
  // hold-off counted here when the stimulus asks for one.
  initial begin
    int hold;
    refl.ready = 0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        refl.ready <= 0;
        for (hold = 0; hold < 200; hold++) @(negedge clk);
        sink_hold = 0;
      end
      refl.ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 25);
    end
  end

  // Write a register through a setup and an access cycle.
  task automatic write_index(input logic sel, input logic [15:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {sel, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Offer one ray, with random gaps ahead of it outside the steady stretch.
  task automatic send_ray(input logic [15:0] cosv);
    while (!steady && $urandom_range(99) < 25) begin
      rays.valid <= 0;
      @(negedge clk);
    end
    rays.valid <= 1;
    rays.cos_incident <= cosv;
    @(posedge clk);
    while (!rays.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait out every expected item plus the pipeline depth.
  task automatic drain();
    rays.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // Mostly in-range cosines; some raw random words, a few extremes and small values.
  function automatic logic [15:0] pick_cos();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 16'($signed($urandom_range(65536)) - 32768);
    if (sel < 85) return 16'($urandom());
    if (sel < 92) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    return 16'($urandom_range(64));
  endfunction

  logic [15:0] corner_cos[12] = '{16'h0000, 16'h0001, 16'h4000, 16'h7FFF, 16'hFFFF,
                                  16'hC000, 16'h8001, 16'h8000, 16'h2D41, 16'hD2BF,
                                  16'h0800, 16'hF800};
  logic [15:0] corner_out[6] = '{16'd4096, 16'd1024, 16'hFFFF, 16'd6144, 16'd0, 16'd5461};
  logic [15:0] corner_in[6] = '{16'd6144, 16'hFFFF, 16'd1024, 16'd6144, 16'd4096, 16'd0};

  initial begin
    int k;
    int phase;
    rst = 1;
    stim_done = 0;
    sink_hold = 0;
    steady = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    rays.valid = 0;
    rays.cos_incident = '0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset indices, then extreme, equal and zero index pairs.
    for (k = 0; k < 12; k++) send_ray(corner_cos[k]);
    drain();
    for (phase = 1; phase < 6; phase++) begin
      write_index(dfr_pkg::REG_OUTSIDE, corner_out[phase]);
      write_index(dfr_pkg::REG_INSIDE, corner_in[phase]);
      for (k = 0; k < 3; k++) send_ray(corner_cos[(phase * 3 + k) % 12]);
      drain();
    end

    // Random phases with fresh indices; the second one without idling and with a
    // long receiver hold-off so the input stalls.
    for (phase = 0; phase < 13; phase++) begin
      if (phase % 4 == 3) begin
        write_index(dfr_pkg::REG_OUTSIDE, $urandom_range(1) ? 16'hFFFF : 16'd1024);
      end else begin
        write_index(dfr_pkg::REG_OUTSIDE, 16'($urandom_range(65535, 1024)));
      end
      if (phase % 5 == 2) write_index(dfr_pkg::REG_INSIDE, corner_out[phase % 3]);
      else write_index(dfr_pkg::REG_INSIDE, 16'($urandom_range(65535, 1024)));
      steady = (phase == 1);
      if (phase == 1) sink_hold = 1;
      for (k = 0; k < RANDOM_ITEMS / 13; k++) send_ray(pick_cos());
      drain();
      steady = 0;
    end

    stim_done = 1;
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
